// ===== design/jila_pkg.sv =====
// Package: shared types, operation codes and constants for the integer/long ALU.
package jila_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned IntBits   = 32;
   localparam int unsigned DivStages = 64;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_DIV  = 4'd3,
      OP_REM  = 4'd4,
      OP_NEG  = 4'd5,
      OP_SHL  = 4'd6,
      OP_SHR  = 4'd7,
      OP_USHR = 4'd8,
      OP_AND  = 4'd9,
      OP_OR   = 4'd10,
      OP_XOR  = 4'd11
   } op_type;

   typedef struct packed {
      logic [3:0]         cmd;
      logic               is_long;
      logic signed [63:0] first_operand;
      logic signed [63:0] second_operand;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result;
      logic               divide_by_zero;
   } rsp_type;

   // Per-item control that travels down the pipeline beside the data.
   typedef struct packed {
      logic       valid;
      logic [3:0] cmd;
      logic       is_long;
      logic       neg_q;
      logic       neg_r;
      logic       dz;
      logic       ovf;
   } ctl_type;

   function automatic logic [63:0] sext32(input logic [63:0] x);
      sext32 = {{(DataWidth - IntBits){x[IntBits-1]}}, x[IntBits-1:0]};
   endfunction

endpackage

// ===== design/jila_mul.sv =====
// Module: pipelined 64x64 low-half multiplier from 32x32 partial products.
module jila_mul (
   input  logic        clock,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);
   logic [63:0] ll_ff, ll_in;
   logic [31:0] lh_ff, lh_in, hl_ff, hl_in;
   logic [63:0] p_ff, p_in;

   always_comb begin
      ll_in = {32'd0, a[31:0]} * {32'd0, b[31:0]};
      lh_in = a[31:0] * b[63:32];
      hl_in = a[63:32] * b[31:0];
      p_in  = ll_ff + {lh_ff + hl_ff, 32'd0};
   end

   always_ff @(posedge clock) begin
      ll_ff <= ll_in;
      lh_ff <= lh_in;
      hl_ff <= hl_in;
      p_ff  <= p_in;
   end

   assign p = p_ff;
endmodule

// ===== design/jvm_integer_long_alu_top.sv =====
// Module: top level of the pipelined JVM integer/long ALU.
//
// Usage:
//   Drive req_payload and raise start; the transaction is accepted at the
//   rising edge where start is high and busy is low. busy is tied low: the
//   unit accepts one transaction every cycle.
//   Each transaction yields one result on rsp_payload, marked by rsp_valid
//   for exactly one cycle, in issue order.
//   All operations share one path length so results never reorder. The
//   depth is set by the restoring divider, which retires one quotient bit
//   per stage over the full 64-bit width; the multiplier uses two register
//   stages of 32x32 partial products.
//   Throughput: one transaction per cycle.
//   Reset (synchronous, active high) clears all valid bits; items in flight
//   are dropped. Payload registers are not reset.
//   The receiver cannot stall: results are simply presented one cycle each.
//   Zero divisor on div/rem returns 0 with divide_by_zero set.
module jvm_integer_long_alu_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  jila_pkg::req_type req_payload,
   output logic              rsp_valid,
   output jila_pkg::rsp_type rsp_payload
);
   localparam int unsigned W         = jila_pkg::DataWidth;
   localparam int unsigned DivStages = jila_pkg::DivStages;

   // Stage 0: operand prep, simple ops, magnitudes.
   jila_pkg::ctl_type s0_ctl_ff, s0_ctl_in;
   logic [W-1:0] s0_a_ff, s0_a_in, s0_b_ff, s0_b_in;
   logic [W-1:0] s0_ma_ff, s0_ma_in, s0_mb_ff, s0_mb_in;
   logic [W-1:0] s0_res_ff, s0_res_in;

   logic [W-1:0] a, b;
   logic [5:0]   sh;

   assign busy = 1'b0;

   always_comb begin
      a  = req_payload.is_long ? req_payload.first_operand
                               : jila_pkg::sext32(req_payload.first_operand);
      b  = req_payload.is_long ? req_payload.second_operand
                               : jila_pkg::sext32(req_payload.second_operand);
      sh = req_payload.is_long ? b[5:0] : {1'b0, b[4:0]};
      s0_ctl_in.valid   = start;
      s0_ctl_in.cmd     = req_payload.cmd;
      s0_ctl_in.is_long = req_payload.is_long;
      s0_ctl_in.neg_q   = a[W-1] ^ b[W-1];
      s0_ctl_in.neg_r   = a[W-1];
      s0_ctl_in.dz      = (b == '0);
      s0_ctl_in.ovf     = 1'b0;
      s0_a_in  = a;
      s0_b_in  = b;
      s0_ma_in = a[W-1] ? (~a + 1'b1) : a;
      s0_mb_in = b[W-1] ? (~b + 1'b1) : b;
      unique case (req_payload.cmd)
         jila_pkg::OP_ADD:  s0_res_in = a + b;
         jila_pkg::OP_SUB:  s0_res_in = a - b;
         jila_pkg::OP_NEG:  s0_res_in = ~a + 1'b1;
         jila_pkg::OP_SHL:  s0_res_in = a << sh;
         jila_pkg::OP_SHR:  s0_res_in = $unsigned($signed(a) >>> sh);
         jila_pkg::OP_USHR: s0_res_in = req_payload.is_long ? (a >> sh)
                                        : ({32'd0, a[31:0]} >> sh);
         jila_pkg::OP_AND:  s0_res_in = a & b;
         jila_pkg::OP_OR:   s0_res_in = a | b;
         jila_pkg::OP_XOR:  s0_res_in = a ^ b;
         default:           s0_res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff.valid <= 1'b0;
      end else begin
         s0_ctl_ff.valid <= s0_ctl_in.valid;
      end
      s0_ctl_ff.cmd     <= s0_ctl_in.cmd;
      s0_ctl_ff.is_long <= s0_ctl_in.is_long;
      s0_ctl_ff.neg_q   <= s0_ctl_in.neg_q;
      s0_ctl_ff.neg_r   <= s0_ctl_in.neg_r;
      s0_ctl_ff.dz      <= s0_ctl_in.dz;
      s0_ctl_ff.ovf     <= s0_ctl_in.ovf;
      s0_a_ff   <= s0_a_in;
      s0_b_ff   <= s0_b_in;
      s0_ma_ff  <= s0_ma_in;
      s0_mb_ff  <= s0_mb_in;
      s0_res_ff <= s0_res_in;
   end

   // Multiplier, two stages, started from stage 0 registers.
   logic [W-1:0] mul_p;
   jila_mul u_mul (
      .clock (clock),
      .a     (s0_a_ff),
      .b     (s0_b_ff),
      .p     (mul_p)
   );

   // Restoring divider: one quotient bit per stage on magnitudes.
   jila_pkg::ctl_type dv_ctl_ff [DivStages+1];
   logic [W-1:0] dv_rem_ff [DivStages+1];
   logic [W-1:0] dv_quo_ff [DivStages+1];
   logic [W-1:0] dv_div_ff [DivStages+1];
   logic [W-1:0] dv_res_ff [DivStages+1];
   logic [W-1:0] dv_mul_ff [DivStages+1];

   always_comb begin
      dv_ctl_ff[0] = s0_ctl_ff;
      dv_rem_ff[0] = '0;
      dv_quo_ff[0] = s0_ma_ff;
      dv_div_ff[0] = s0_mb_ff;
      dv_res_ff[0] = s0_res_ff;
      dv_mul_ff[0] = '0;
   end

   for (genvar i = 0; i < DivStages; i++) begin : g_div
      logic [W:0]   trial;
      logic [W-1:0] rem_in, quo_in, mul_in;
      always_comb begin
         trial  = {dv_rem_ff[i], dv_quo_ff[i][W-1]} - {1'b0, dv_div_ff[i]};
         rem_in = trial[W] ? {dv_rem_ff[i][W-2:0], dv_quo_ff[i][W-1]} : trial[W-1:0];
         quo_in = {dv_quo_ff[i][W-2:0], ~trial[W]};
         // Capture the product in the stage where it lines up with its item.
         mul_in = (i == 2) ? mul_p : dv_mul_ff[i];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ctl_ff[i+1].valid <= 1'b0;
         end else begin
            dv_ctl_ff[i+1].valid <= dv_ctl_ff[i].valid;
         end
         dv_ctl_ff[i+1].cmd     <= dv_ctl_ff[i].cmd;
         dv_ctl_ff[i+1].is_long <= dv_ctl_ff[i].is_long;
         dv_ctl_ff[i+1].neg_q   <= dv_ctl_ff[i].neg_q;
         dv_ctl_ff[i+1].neg_r   <= dv_ctl_ff[i].neg_r;
         dv_ctl_ff[i+1].dz      <= dv_ctl_ff[i].dz;
         dv_ctl_ff[i+1].ovf     <= dv_ctl_ff[i].ovf;
         dv_rem_ff[i+1] <= rem_in;
         dv_quo_ff[i+1] <= quo_in;
         dv_div_ff[i+1] <= dv_div_ff[i];
         dv_res_ff[i+1] <= dv_res_ff[i];
         dv_mul_ff[i+1] <= mul_in;
      end
   end

   // Final stages: sign fix, select, int sign-extension, output register.
   jila_pkg::ctl_type fc;
   logic [W-1:0] fq, fr, sel;
   logic         out_dz_in, out_valid_in;
   logic [W-1:0] out_res_in;
   logic         out_valid_ff, out_dz_ff;
   logic [W-1:0] out_res_ff;

   always_comb begin
      fc = dv_ctl_ff[DivStages];
      fq = fc.neg_q ? (~dv_quo_ff[DivStages] + 1'b1) : dv_quo_ff[DivStages];
      fr = fc.neg_r ? (~dv_rem_ff[DivStages] + 1'b1) : dv_rem_ff[DivStages];
      priority if (fc.cmd == jila_pkg::OP_MUL) begin
         sel = dv_mul_ff[DivStages];
      end else if (fc.cmd == jila_pkg::OP_DIV) begin
         sel = fc.dz ? '0 : fq;
      end else if (fc.cmd == jila_pkg::OP_REM) begin
         sel = fc.dz ? '0 : fr;
      end else begin
         sel = dv_res_ff[DivStages];
      end
      out_res_in   = fc.is_long ? sel : jila_pkg::sext32(sel);
      out_dz_in    = fc.dz && (fc.cmd == jila_pkg::OP_DIV || fc.cmd == jila_pkg::OP_REM);
      out_valid_in = fc.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_dz_ff  <= out_dz_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid                  = out_valid_ff;
   assign rsp_payload.result         = out_res_ff;
   assign rsp_payload.divide_by_zero = out_dz_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, DivStages + 2))
      else $error("result without matching request");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.divide_by_zero) |-> (rsp_payload.result == '0))
      else $error("divide by zero with nonzero result");
   a_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
`endif
endmodule
